@@ rtl/core/jsp_pkg.sv @@
// ----------------------------------------------------------------------------
// jsp_pkg: shared types and constants for the JSON structure parser
// Frame states, event codes, error codes, character classes and records.
// ----------------------------------------------------------------------------
package jsp_pkg;

	localparam int STACK_DEPTH_DEF  = 64;
	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int MAX_EVENTS       = 4;
	localparam int NUM_LEN_MAX      = 64;
	localparam int LIT_KEEP         = 7;

	typedef enum logic [3:0] {
		F_VALUE    = 4'd0,
		F_OBJ      = 4'd1,
		F_OBJ_KEY  = 4'd2,
		F_OBJ_VAL  = 4'd3,
		F_OBJ_VAL2 = 4'd4,
		F_ARR      = 4'd5,
		F_ARR_VAL  = 4'd6,
		F_STR      = 4'd7,
		F_NUM      = 4'd8,
		F_LIT      = 4'd9,
		F_DELIM    = 4'd10
	} frame_t;

	typedef enum logic [3:0] {
		EV_OBJ_OPEN = 4'd0,
		EV_ARR_OPEN = 4'd1,
		EV_STRING   = 4'd2,
		EV_NUMBER   = 4'd3,
		EV_LITERAL  = 4'd4,
		EV_MEMBER   = 4'd5,
		EV_ELEMENT  = 4'd6,
		EV_CLOSE    = 4'd7,
		EV_DOC_END  = 4'd8,
		EV_ERROR    = 4'd9
	} evcode_t;

	typedef enum logic [2:0] {
		C_OTH = 3'd0,
		C_SPC = 3'd1,
		C_DM1 = 3'd2,
		C_DM2 = 3'd3,
		C_NUM = 3'd4,
		C_LIT = 3'd5
	} cclass_t;

	typedef enum logic [1:0] {
		A_NONE   = 2'd0,
		A_FINISH = 2'd1,
		A_POP    = 2'd2,
		A_PUSH   = 2'd3
	} action_t;

	localparam logic [31:0] ERR_OVERFLOW = 32'd1;
	localparam logic [31:0] ERR_LIT_LEN  = 32'd2;
	localparam logic [31:0] ERR_LIT_BAD  = 32'd3;
	localparam logic [31:0] ERR_NUM_LEN  = 32'd4;
	localparam logic [31:0] ERR_ILLEGAL  = 32'd5;
	localparam logic [31:0] ERR_UNCLOSED = 32'd6;

	localparam logic [31:0] LIT_NULL  = 32'd0;
	localparam logic [31:0] LIT_TRUE  = 32'd1;
	localparam logic [31:0] LIT_FALSE = 32'd2;

	localparam logic [55:0] PAT_NULL  = 56'h6E756C6C;
	localparam logic [55:0] PAT_TRUE  = 56'h74727565;
	localparam logic [55:0] PAT_FALSE = 56'h66616C7365;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		evcode_t     code;
		logic        key;
		logic [31:0] off;
		logic [31:0] len;
		logic [31:0] det;
		logic [6:0]  depth;
	} event_t;

	typedef struct packed {
		event_t [MAX_EVENTS-1:0] e;
		logic [2:0]              n;
	} evq_t;

	typedef struct packed {
		frame_t      st;
		logic [31:0] cnt;
	} frame_rec_t;

	function automatic cclass_t classify(input logic [7:0] b);
		cclass_t c;
		c = C_OTH;
		if (b == CH_NUL || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_SPACE)
			c = C_SPC;
		else if (b == CH_LBRACK || b == CH_LBRACE)
			c = C_DM1;
		else if (b == CH_COMMA || b == CH_RBRACK || b == CH_RBRACE)
			c = C_DM2;
		else if (b == CH_PLUS || b == CH_MINUS || b == CH_DOT ||
			(b >= 8'h30 && b <= 8'h39))
			c = C_NUM;
		else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
			c = C_LIT;
		return c;
	endfunction

	// append one event, dropping anything past the queue size
	function automatic evq_t add_ev(input evq_t q, input evcode_t code, input logic key,
		input logic [31:0] off, input logic [31:0] len, input logic [31:0] det,
		input logic [6:0] depth);
		evq_t r;
		r = q;
		if (q.n < 3'(MAX_EVENTS)) begin
			r.e[q.n[1:0]] = '{code: code, key: key, off: off, len: len, det: det,
				depth: depth};
			r.n = q.n + 3'd1;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/json_structure_parser.sv @@
// ----------------------------------------------------------------------------
// json_structure_parser: byte-serial JSON pushdown recognizer
// Tracks nesting in a frame stack and reports token and structure events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one JSON text byte per item on s_tdata; s_tlast marks the
//   terminator item, which finishes the document and clears the parser.
//   Master channel: zero to four events per byte, in order; m_tlast is set on
//   the final event of a byte.
//   A byte enters an input register and is evaluated there; its events are
//   registered in the result slots that drive m_t*. Throughput: one byte
//   per cycle while each byte yields at most one event, pops no frames and
//   m_tready is high. A byte with n events holds the result slots until all
//   n are taken. A byte that pops frames stalls the next byte while the two
//   cached frames under the top reload from the stack memory (two read ports).
//   The top frame and the two below it live in registers; every frame pushed
//   down is also written to the stack memory, so the memory copy is current.
//   Reset: all control clears at once; the stack memory needs no clearing,
//   since every frame below the top has been written before it is read.
//   Stall: if the receiver holds m_tready low, results wait in their slots,
//   one more byte waits in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module json_structure_parser #(
	parameter int STACK_DEPTH  = jsp_pkg::STACK_DEPTH_DEF,
	parameter int OFFSET_WIDTH = jsp_pkg::OFFSET_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] text_byte
	input  logic         s_tlast,   // end_of_text
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [31:0] token_offset, [63:32] token_length,
	                                // [95:64] detail, [102:96] nesting_depth, [103] 0
	output logic [4:0]   m_tuser,   // [3:0] event_res, [4] string_is_key
	output logic         m_tlast    // last_of_byte
);
	import jsp_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH);
	localparam int OW  = OFFSET_WIDTH;

	// input register
	logic       in_v_q;
	logic [7:0] byte_q;
	logic       eot_q;

	// parser state
	logic [OW-1:0]  pos_q;
	logic [OW-1:0]  tb_q;
	logic           esc_q;
	logic [55:0]    lch_q;
	logic [3:0]     lcn_q;
	logic           err_q;
	logic [31:0]    tvc_q;
	logic [SPW-1:0] sp_q;
	frame_t         top_st_q, a_st_q, b_st_q;
	logic [31:0]    top_cnt_q, a_cnt_q, b_cnt_q;
	logic           refill_q;

	// stack memory
	frame_rec_t     stk_mem [STACK_DEPTH];
	frame_rec_t     rd0_q, rd1_q;

	// result slots
	event_t         res_q [MAX_EVENTS];
	logic [2:0]     res_cnt_q;

	logic           go;
	logic           slot_free;

	// next-state values
	frame_t         st_t, st_a, st_b;
	logic [31:0]    cnt_t, cnt_a, cnt_b;
	logic [SPW-1:0] sp;
	logic [OW-1:0]  tb, pos_n, len, pos;
	logic [55:0]    lch;
	logic [3:0]     lcn;
	logic           err, esc;
	logic [31:0]    tvc;
	logic           popped;
	logic           we;
	logic [SPW-1:0] wa;
	frame_rec_t     wd;
	evq_t           evq;
	logic [SPW-1:0] ra0, ra1;

	logic [SPW+1:0] sp_x, spq_x;

	assign slot_free = (res_cnt_q == 3'd0) || (res_cnt_q == 3'd1 && m_tready);
	assign go        = in_v_q && !refill_q && slot_free;
	assign s_tready  = !in_v_q || go;

	assign m_tvalid = (res_cnt_q != 3'd0);
	assign m_tlast  = (res_cnt_q == 3'd1);
	assign m_tdata  = {1'b0, res_q[0].depth, res_q[0].det, res_q[0].len, res_q[0].off};
	assign m_tuser  = {res_q[0].key, res_q[0].code};

	assign ra0   = sp - SPW'(1);
	assign ra1   = sp - SPW'(2);
	assign spq_x = (SPW+2)'(sp_q);

	// one byte: up to three dependent frame steps
	always_comb begin
		logic [7:0]    b;
		cclass_t       c;
		logic          run, again, clr_cnt, key;
		action_t       act;
		frame_t        push_fs;
		logic          pre_v, post_v;
		evcode_t       pre_c, post_c;
		logic          post_key;
		logic [31:0]   pre_off, pre_len, pre_det, post_off, post_len, post_det;
		logic [31:0]   kind;
		logic          kind_ok;

		st_t   = top_st_q;  cnt_t = top_cnt_q;
		st_a   = a_st_q;    cnt_a = a_cnt_q;
		st_b   = b_st_q;    cnt_b = b_cnt_q;
		sp     = sp_q;
		tb     = tb_q;
		lch    = lch_q;
		lcn    = lcn_q;
		err    = err_q;
		esc    = esc_q;
		tvc    = tvc_q;
		popped = 1'b0;
		we     = 1'b0;
		wa     = sp_q;
		wd     = '{st: top_st_q, cnt: top_cnt_q};
		evq    = '0;
		pos    = pos_q;
		len    = pos_q - tb_q;
		pos_n  = pos_q + OW'(1);
		b      = eot_q ? CH_NUL : byte_q;
		run    = 1'b0;
		sp_x   = '0;
		if (!err_q) begin
			if (esc_q) esc = 1'b0;
			else run = 1'b1;
		end

		for (int k = 0; k < 3; k++) begin
			if (run) begin
				c        = classify(b);
				again    = 1'b0;
				clr_cnt  = 1'b0;
				act      = A_NONE;
				push_fs  = F_VALUE;
				pre_v    = 1'b0;  post_v = 1'b0;
				pre_c    = EV_ERROR;  post_c = EV_CLOSE;
				post_key = 1'b0;
				pre_off  = 32'(pos);  pre_len = '0;  pre_det = ERR_ILLEGAL;
				post_off = 32'(pos);  post_len = '0;  post_det = '0;
				kind     = LIT_NULL;
				kind_ok  = 1'b0;
				key      = 1'b0;
				case (st_t)
					F_VALUE: begin
						if (c != C_SPC) begin
							if (b == CH_LBRACK || b == CH_LBRACE || b == CH_QUOTE ||
								c == C_NUM || c == C_LIT) begin
								if (b == CH_LBRACK) push_fs = F_ARR;
								else if (b == CH_LBRACE) push_fs = F_OBJ;
								else if (b == CH_QUOTE) push_fs = F_STR;
								else if (c == C_NUM) push_fs = F_NUM;
								else push_fs = F_LIT;
								if (sp != '0) st_t = push_fs;
								else act = A_PUSH;
								if (b == CH_LBRACK) begin
									clr_cnt = 1'b1;
									post_v  = 1'b1;
									post_c  = EV_ARR_OPEN;
								end else if (b == CH_LBRACE) begin
									post_v = 1'b1;
									post_c = EV_OBJ_OPEN;
								end else if (b == CH_QUOTE) begin
									tb = pos + OW'(1);
								end else begin
									tb = pos;
									if (c == C_LIT) begin
										lch = 56'(b);
										lcn = 4'd1;
									end
								end
							end else begin
								pre_v = 1'b1;
							end
						end
					end
					F_STR: begin
						if (b == CH_BSLASH) begin
							esc = 1'b1;
						end else if (b == CH_QUOTE) begin
							key      = (sp != '0) && (st_a == F_OBJ_KEY);
							act      = A_FINISH;
							post_v   = 1'b1;
							post_c   = EV_STRING;
							post_key = key;
							post_off = 32'(tb_q);
							post_len = 32'(len);
						end
					end
					F_NUM: begin
						if (c == C_SPC || c == C_DM2) begin
							if (len >= OW'(NUM_LEN_MAX)) begin
								pre_v   = 1'b1;
								pre_det = ERR_NUM_LEN;
								pre_off = 32'(tb_q);
								pre_len = 32'(len);
							end else begin
								act      = A_FINISH;
								post_v   = 1'b1;
								post_c   = EV_NUMBER;
								post_off = 32'(tb_q);
								post_len = 32'(len);
								again    = 1'b1;
							end
						end
					end
					F_LIT: begin
						if (c != C_SPC && c != C_DM2) begin
							if (lcn < 4'(LIT_KEEP)) lch = {lch[47:0], b};
							if (lcn < 4'd8) lcn = lcn + 4'd1;
						end else if (lcn > 4'(LIT_KEEP)) begin
							pre_v   = 1'b1;
							pre_det = ERR_LIT_LEN;
							pre_off = 32'(tb_q);
							pre_len = 32'(len);
						end else begin
							if (lcn == 4'd4 && lch == PAT_NULL) begin
								kind = LIT_NULL;  kind_ok = 1'b1;
							end else if (lcn == 4'd4 && lch == PAT_TRUE) begin
								kind = LIT_TRUE;  kind_ok = 1'b1;
							end else if (lcn == 4'd5 && lch == PAT_FALSE) begin
								kind = LIT_FALSE; kind_ok = 1'b1;
							end
							if (kind_ok) begin
								act      = A_FINISH;
								post_v   = 1'b1;
								post_c   = EV_LITERAL;
								post_off = 32'(tb_q);
								post_len = 32'(len);
								post_det = kind;
								again    = 1'b1;
							end else begin
								pre_v   = 1'b1;
								pre_det = ERR_LIT_BAD;
								pre_off = 32'(tb_q);
								pre_len = 32'(len);
							end
						end
					end
					F_DELIM: begin
						if (b == CH_COMMA) begin
							act = A_POP;
						end else if (c == C_DM2 || b == CH_NUL) begin
							act   = A_POP;
							again = 1'b1;
						end else if (c != C_SPC) begin
							pre_v = 1'b1;
						end
					end
					F_OBJ: begin
						if (c != C_SPC) begin
							if (b == CH_QUOTE) begin
								tb      = pos + OW'(1);
								st_t    = F_OBJ_KEY;
								act     = A_PUSH;
								push_fs = F_STR;
							end else if (b == CH_RBRACE) begin
								act    = A_FINISH;
								post_v = 1'b1;
							end else begin
								pre_v = 1'b1;
							end
						end
					end
					F_OBJ_KEY: begin
						if (c != C_SPC) begin
							if (b == CH_COLON) st_t = F_OBJ_VAL;
							else pre_v = 1'b1;
						end
					end
					F_OBJ_VAL, F_ARR: begin
						if (c != C_SPC) begin
							if (st_t == F_ARR && b == CH_RBRACKET_OR_NONE(b)) begin
								act    = A_FINISH;
								post_v = 1'b1;
							end else if (!(c == C_DM1 || c == C_NUM || c == C_LIT ||
								b == CH_QUOTE)) begin
								pre_v = 1'b1;
							end else begin
								st_t    = (st_t == F_ARR) ? F_ARR_VAL : F_OBJ_VAL2;
								act     = A_PUSH;
								push_fs = F_VALUE;
								again   = 1'b1;
							end
						end
					end
					F_OBJ_VAL2: begin
						if (c != C_SPC) begin
							if (b == CH_RBRACE || b == CH_COMMA) begin
								pre_v = 1'b1;
								pre_c = EV_MEMBER;
								pre_det = '0;
								if (b == CH_RBRACE) begin
									act    = A_FINISH;
									post_v = 1'b1;
								end else begin
									st_t = F_OBJ;
								end
							end else begin
								pre_v = 1'b1;
							end
						end
					end
					F_ARR_VAL: begin
						if (c != C_SPC) begin
							if (b == CH_RBRACK || b == CH_COMMA) begin
								cnt_t   = cnt_t + 32'd1;
								pre_v   = 1'b1;
								pre_c   = EV_ELEMENT;
								pre_det = cnt_t;
								if (b == CH_RBRACK) begin
									act    = A_FINISH;
									post_v = 1'b1;
								end else begin
									st_t = F_ARR;
								end
							end else begin
								pre_v = 1'b1;
							end
						end
					end
					default: begin
						pre_v = 1'b1;
					end
				endcase

				if (pre_v) begin
					if (pre_c == EV_ERROR) err = 1'b1;
					evq = add_ev(evq, pre_c, 1'b0, pre_off, pre_len, pre_det, 7'(sp));
				end

				case (act)
					A_FINISH: begin
						sp_x = (SPW+2)'(sp);
						if (sp_x > (SPW+2)'(1)) begin
							sp     = sp - SPW'(1);
							st_t   = st_a;  cnt_t = cnt_a;
							st_a   = st_b;  cnt_a = cnt_b;
							popped = 1'b1;
						end else begin
							st_t = F_DELIM;
							tvc  = tvc + 32'd1;
						end
					end
					A_POP: begin
						if (sp != '0) begin
							sp     = sp - SPW'(1);
							st_t   = st_a;  cnt_t = cnt_a;
							st_a   = st_b;  cnt_a = cnt_b;
							popped = 1'b1;
						end
					end
					A_PUSH: begin
						if (sp == SPW'(STACK_DEPTH - 1)) begin
							err    = 1'b1;
							again  = 1'b0;
							post_v = 1'b0;
							evq = add_ev(evq, EV_ERROR, 1'b0, 32'(pos), '0, ERR_OVERFLOW,
								7'(sp));
						end else begin
							we    = 1'b1;
							wa    = sp;
							wd    = '{st: st_t, cnt: cnt_t};
							st_b  = st_a;  cnt_b = cnt_a;
							st_a  = st_t;  cnt_a = cnt_t;
							sp    = sp + SPW'(1);
							st_t  = push_fs;
							cnt_t = '0;
						end
					end
					default: ;
				endcase

				if (clr_cnt) cnt_t = '0;

				if (post_v)
					evq = add_ev(evq, post_c, post_key, post_off, post_len, post_det,
						7'(sp));

				if (err || !again) run = 1'b0;
			end
		end

		if (eot_q) begin
			if (!err && st_t != F_VALUE)
				evq = add_ev(evq, EV_ERROR, 1'b0, 32'(pos), '0, ERR_UNCLOSED, 7'(sp));
			evq    = add_ev(evq, EV_DOC_END, 1'b0, 32'(pos), '0, tvc, '0);
			st_t   = F_VALUE;  cnt_t = '0;
			st_a   = F_VALUE;  cnt_a = '0;
			st_b   = F_VALUE;  cnt_b = '0;
			sp     = '0;
			tb     = '0;
			esc    = 1'b0;
			lch    = '0;
			lcn    = '0;
			err    = 1'b0;
			tvc    = '0;
			pos_n  = '0;
			popped = 1'b0;
		end
	end

	// right bracket test kept as a plain compare
	function automatic logic [7:0] CH_RBRACKET_OR_NONE(input logic [7:0] x);
		return (x == CH_RBRACK) ? x : ~x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q <= 1'b0;
			byte_q <= '0;
			eot_q  <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_v_q <= 1'b1;
			byte_q <= s_tdata;
			eot_q  <= s_tlast;
		end else if (go) begin
			in_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			tb_q      <= '0;
			esc_q     <= 1'b0;
			lch_q     <= '0;
			lcn_q     <= '0;
			err_q     <= 1'b0;
			tvc_q     <= '0;
			sp_q      <= '0;
			top_st_q  <= F_VALUE;
			top_cnt_q <= '0;
			a_st_q    <= F_VALUE;
			a_cnt_q   <= '0;
			b_st_q    <= F_VALUE;
			b_cnt_q   <= '0;
			refill_q  <= 1'b0;
		end else if (go) begin
			pos_q     <= pos_n;
			tb_q      <= tb;
			esc_q     <= esc;
			lch_q     <= lch;
			lcn_q     <= lcn;
			err_q     <= err;
			tvc_q     <= tvc;
			sp_q      <= sp;
			top_st_q  <= st_t;
			top_cnt_q <= cnt_t;
			a_st_q    <= st_a;
			a_cnt_q   <= cnt_a;
			b_st_q    <= st_b;
			b_cnt_q   <= cnt_b;
			refill_q  <= popped;
		end else if (refill_q) begin
			// reload the two frames under the top after a pop
			a_st_q   <= (spq_x >= (SPW+2)'(2)) ? rd0_q.st  : F_VALUE;
			a_cnt_q  <= (spq_x >= (SPW+2)'(2)) ? rd0_q.cnt : '0;
			b_st_q   <= (spq_x >= (SPW+2)'(3)) ? rd1_q.st  : F_VALUE;
			b_cnt_q  <= (spq_x >= (SPW+2)'(3)) ? rd1_q.cnt : '0;
			refill_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && we) stk_mem[wa] <= wd;
		rd0_q <= stk_mem[ra0];
		rd1_q <= stk_mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (go) begin
			res_cnt_q <= evq.n;
		end else if (m_tvalid && m_tready) begin
			res_cnt_q <= res_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < MAX_EVENTS; i++) res_q[i] <= evq.e[i];
		end else if (m_tvalid && m_tready) begin
			for (int i = 0; i < MAX_EVENTS - 1; i++) res_q[i] <= res_q[i+1];
		end
	end

`ifndef SYNTH
	a_refill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		refill_q |-> $past(go))
		else $error("frame reload without a preceding evaluation");
	a_no_eval_in_refill: assert property (@(posedge clk) disable iff (!arst_n)
		refill_q |-> !go)
		else $error("byte evaluated while cached frames are stale");
	a_frame0_value: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q == '0) |-> (top_st_q == F_VALUE))
		else $error("bottom frame left value-expected state");
	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= 3'(MAX_EVENTS))
		else $error("result slot count out of range");
`endif

endmodule
